FILE: rtl/fence_status_tracker_core_macros.svh
// ---------------------------------------------------------------------------
// Fence status tracker assertion macros
// Concurrent assertion shorthands; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef FENCE_STATUS_TRACKER_CORE_MACROS_SVH
`define FENCE_STATUS_TRACKER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication on clk, off while rst_n is low
`define FST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fence status tracker: implication check failed");

// Next-cycle implication on clk, off while rst_n is low
`define FST_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fence status tracker: next-cycle check failed");

`else

`define FST_ASSERT_IMP(lbl, ante, cons)
`define FST_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/fst_pkg.sv
// ---------------------------------------------------------------------------
// Fence status tracker package
// Status and mode codes, transaction payload types shared by the modules.
// ---------------------------------------------------------------------------
package fst_pkg;

    typedef logic [3:0] status_t;
    typedef logic [1:0] mode_t;

    // Status codes
    localparam status_t ST_UNKNOWN       = 4'd0;
    localparam status_t ST_NOT_STARTED   = 4'd1;
    localparam status_t ST_NORMAL        = 4'd2;
    localparam status_t ST_MAYBE_OUT     = 4'd3;
    localparam status_t ST_ESCAPED       = 4'd4;
    localparam status_t ST_BEACON        = 4'd5;
    localparam status_t ST_BEACON_NORMAL = 4'd6;
    localparam status_t ST_INVALID       = 4'd7;
    localparam status_t ST_BLE_OFF       = 4'd8;

    // Item kinds
    localparam mode_t MODE_EVAL  = 2'd0;
    localparam mode_t MODE_ZAP   = 2'd1;
    localparam mode_t MODE_CLEAR = 2'd2;
    localparam mode_t MODE_FORCE = 2'd3;

    // Zone codes that keep the animal from counting as inside
    localparam logic [2:0] ZONE_NONE = 3'd0;
    localparam logic [2:0] ZONE_WARN = 3'd1;

    // Configuration register indexes
    localparam logic CFG_PAIN_LIMIT     = 1'b0;
    localparam logic CFG_OUT_TIME_LIMIT = 1'b1;

    localparam logic [7:0]  PAIN_LIMIT_RST     = 8'd3;
    localparam logic [15:0] OUT_TIME_LIMIT_RST = 16'd60;
    localparam logic [15:0] PAIN_MAX           = 16'hFFFF;

    localparam int ITEM_DATA_W = 43;
    localparam int TDATA_IN_W  = 48;
    localparam int RES_W       = 23;
    localparam int TDATA_OUT_W = 24;

    // Input item, first field in the highest bits
    typedef struct packed {
        mode_t       mode;
        status_t     target_status;
        logic [31:0] out_seconds;
        logic [2:0]  zone;
        logic        fix_ok;
        logic        def_valid;
        logic        fence_valid;
        logic        beacon_near;
    } item_t;

    // Result item, first field in the highest bits
    typedef struct packed {
        logic [15:0] pain_count;
        logic        rejected;
        logic        escape_pulse;
        logic        changed;
        status_t     fence_state;
    } result_t;

    // Configuration values seen by the datapath
    typedef struct packed {
        logic [7:0]  pain_limit;
        logic [15:0] out_time_limit;
    } cfg_t;

endpackage

FILE: rtl/fst_eval.sv
// ---------------------------------------------------------------------------
// Fence status evaluation
// Next status of the nine-state machine for an evaluate transaction.
// ---------------------------------------------------------------------------
module fst_eval
(
    input  fst_pkg::status_t status,
    input  fst_pkg::item_t   item,
    input  logic [15:0]      pain_counter,
    input  fst_pkg::cfg_t    cfg,
    output fst_pkg::status_t next_status
);
    import fst_pkg::*;

    logic in_fence;
    logic pained;
    logic secs_over;
    logic secs_under;

    // Derive the conditions that steer the transitions
    assign in_fence   = item.fence_valid && item.fix_ok &&
                        (item.zone != ZONE_NONE) && (item.zone != ZONE_WARN);
    assign pained     = pain_counter >= {8'd0, cfg.pain_limit};
    assign secs_over  = item.out_seconds > {16'd0, cfg.out_time_limit};
    assign secs_under = item.out_seconds < {16'd0, cfg.out_time_limit};

    // Pick the next status
    always_comb
    begin
        next_status = status;
        unique case (status)
            ST_UNKNOWN:
            begin
                if (item.beacon_near)    next_status = ST_BEACON;
                else if (item.def_valid) next_status = ST_NOT_STARTED;
            end
            ST_NOT_STARTED, ST_ESCAPED:
            begin
                if (item.beacon_near) next_status = ST_BEACON;
                else if (in_fence)    next_status = ST_NORMAL;
            end
            ST_NORMAL:
            begin
                if (item.beacon_near) next_status = ST_BEACON_NORMAL;
                else if (secs_over)   next_status = ST_MAYBE_OUT;
                else if (pained)      next_status = ST_ESCAPED;
            end
            ST_MAYBE_OUT:
            begin
                if (item.beacon_near) next_status = ST_BEACON;
                else if (pained)      next_status = ST_ESCAPED;
                else if (secs_under)  next_status = ST_NORMAL;
            end
            ST_BEACON:
            begin
                if (!item.beacon_near)
                    next_status = item.fence_valid ? ST_NOT_STARTED : ST_UNKNOWN;
            end
            ST_BEACON_NORMAL:
            begin
                if (!item.beacon_near) next_status = ST_NORMAL;
            end
            ST_INVALID, ST_BLE_OFF:
            begin
                next_status = status;
            end
            default:
            begin
                next_status = ST_UNKNOWN;
            end
        endcase
    end

endmodule

FILE: rtl/fst_update.sv
// ---------------------------------------------------------------------------
// Fence status update
// Holds status and pain count; decodes the item kind into the result.
// ---------------------------------------------------------------------------
module fst_update
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  fst_pkg::item_t    item,
    input  fst_pkg::cfg_t     cfg,
    output fst_pkg::result_t  result
);
    import fst_pkg::*;

    status_t     status_reg;
    status_t     status_next;
    logic [15:0] pain_reg;
    logic [15:0] pain_next;
    status_t     eval_status;
    logic        force_ok;
    logic        changed;
    logic        escape;
    logic        rejected;

    fst_eval u_eval
    (
        .status       (status_reg),
        .item         (item),
        .pain_counter (pain_reg),
        .cfg          (cfg),
        .next_status  (eval_status)
    );

    // Flag force targets that may be requested
    always_comb
    begin
        case (item.target_status) inside
            ST_UNKNOWN, ST_NOT_STARTED, ST_INVALID, ST_BLE_OFF: force_ok = 1'b1;
            default:                                              force_ok = 1'b0;
        endcase
    end

    // Decode the item kind
    always_comb
    begin
        status_next = status_reg;
        pain_next   = pain_reg;
        changed     = 1'b0;
        escape      = 1'b0;
        rejected    = 1'b0;
        unique case (item.mode)
            MODE_EVAL:
            begin
                status_next = eval_status;
                changed     = eval_status != status_reg;
                escape      = changed && (eval_status == ST_ESCAPED);
            end
            MODE_ZAP:
            begin
                if (pain_reg != PAIN_MAX)
                    pain_next = pain_reg + 16'd1;
            end
            MODE_CLEAR:
            begin
                pain_next = 16'd0;
            end
            MODE_FORCE:
            begin
                if (!force_ok)
                    rejected = 1'b1;
                else if (item.target_status != status_reg)
                begin
                    if ((item.target_status == ST_NOT_STARTED) && !item.def_valid)
                        rejected = 1'b1;
                    else
                    begin
                        status_next = item.target_status;
                        changed     = 1'b1;
                    end
                end
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    assign result.fence_state  = status_next;
    assign result.changed      = changed;
    assign result.escape_pulse = escape;
    assign result.rejected     = rejected;
    assign result.pain_count   = pain_next;

    // Commit state when the transaction moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= ST_UNKNOWN;
            pain_reg   <= 16'd0;
        end
        else if (advance)
        begin
            status_reg <= status_next;
            pain_reg   <= pain_next;
        end
    end

endmodule

FILE: rtl/fence_status_tracker_core.sv
// ---------------------------------------------------------------------------
// Fence status tracker core: input and result registers pipeline each transaction.
// Throughput 1 transaction per cycle unless a low m_tready stalls the result register.
// Reset: status unknown, pain count 0, pain limit 3, out time limit 60 s.
// ---------------------------------------------------------------------------
module fence_status_tracker_core
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // beacon_near[0], fence_valid[1], def_valid[2], fix_ok[3], zone[6:4],
    // out_seconds[38:7], target_status[42:39], zero fill[47:43]
    input  logic [47:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // fence_state[3:0], changed[4], escape_pulse[5], rejected[6],
    // pain_count[22:7], zero fill[23]
    output logic [23:0] m_tdata
);
    import fst_pkg::*;

    `include "fence_status_tracker_core_macros.svh"

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t result;
    cfg_t    cfg_reg;
    logic    advance;

    // Move a transaction from the input register into the result register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pain_limit     <= PAIN_LIMIT_RST;
            cfg_reg.out_time_limit <= OUT_TIME_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_PAIN_LIMIT)
                cfg_reg.pain_limit <= cfg_data[7:0];
            else
                cfg_reg.out_time_limit <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_item_reg <= {s_tuser, s_tdata[ITEM_DATA_W-1:0]};
    end

    fst_update u_update
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_OUT_W-RES_W){1'b0}}, out_res_reg};

    // Checks
    `FST_ASSERT_IMP(a_escape_is_change, out_valid_reg && out_res_reg.escape_pulse,
        out_res_reg.changed && (out_res_reg.fence_state == ST_ESCAPED))
    `FST_ASSERT_IMP(a_reject_no_change, out_valid_reg && out_res_reg.rejected,
        !out_res_reg.changed && !out_res_reg.escape_pulse)
    `FST_ASSERT_IMP(a_state_in_range, out_valid_reg,
        out_res_reg.fence_state <= ST_BLE_OFF)
    `FST_ASSERT_NXT(a_advance_shows, advance, out_valid_reg)

endmodule
